// ----- src/rbag_pkg.sv -----
// shared types and constants for the rotated blit address generator
`default_nettype none
package rbag_pkg;

  localparam int unsigned MAX_DIM  = 4096;
  localparam int unsigned DIM_W    = 13;   // width, height and stride
  localparam int unsigned POS_W    = 12;   // column, row and origin
  localparam int unsigned BPP_W    = 3;
  localparam int unsigned SRC_W    = 26;
  localparam int unsigned DST_W    = 27;
  localparam int unsigned SIDX_W   = 24;   // source pixel index, below MAX_DIM squared
  localparam int unsigned CFG_IX_W = 3;
  localparam int unsigned CFG_DW   = 13;
  localparam int unsigned IN_DW    = 8;
  localparam int unsigned OUT_DW   = 56;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_DEST_STRIDE = 3'd0,
    CFG_ORIGIN_X    = 3'd1,
    CFG_ORIGIN_Y    = 3'd2,
    CFG_RECT_WIDTH  = 3'd3,
    CFG_RECT_HEIGHT = 3'd4,
    CFG_ROTATION    = 3'd5,
    CFG_BPP         = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SCALE
  } rbag_state_t;

  typedef struct packed {
    logic start;    // request taken, latch position
    logic mul_en;   // capture products
    logic add_en;   // capture pixel indexes
    logic load;     // scale and load the output register
  } rbag_cmd_t;

  typedef struct packed {
    logic out_free; // output register empty or being drained
  } rbag_sts_t;

endpackage
`default_nettype wire

// ----- src/rbag_ctrl.sv -----
// controller state machine sequencing one request through the datapath
`default_nettype none
module rbag_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  rbag_pkg::rbag_sts_t sts,
  output rbag_pkg::rbag_cmd_t cmd
);
  import rbag_pkg::*;

  rbag_state_t state_r;
  rbag_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
      end
      ST_ADD: begin
        cmd.add_en = 1'b1;
      end
      ST_SCALE: begin
        cmd.load = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/rbag_dp.sv -----
// datapath: configuration registers, walk position, address arithmetic, output register
`default_nettype none
module rbag_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rbag_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [rbag_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          restart,
  input  rbag_pkg::rbag_cmd_t           cmd,
  output rbag_pkg::rbag_sts_t           sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rbag_pkg::OUT_DW-1:0]   out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);
  import rbag_pkg::*;

  // configuration
  logic [DIM_W-1:0] dest_stride_r;
  logic [POS_W-1:0] origin_x_r;
  logic [POS_W-1:0] origin_y_r;
  logic [DIM_W-1:0] rect_width_r;
  logic [DIM_W-1:0] rect_height_r;
  rot_t             rotation_r;
  logic [BPP_W-1:0] bpp_r;

  // walk position
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;

  // per request pipeline
  logic [POS_W-1:0] cur_c_r, cur_c_nxt;
  logic [POS_W-1:0] cur_r_r, cur_r_nxt;
  logic             empty_r;
  logic             last_r, last_nxt;
  logic [SIDX_W-1:0] src_prod_r;
  logic [DIM_W-1:0]  src_add_r;
  logic [DST_W-1:0]  dst_prod_r;
  logic [DIM_W-1:0]  dst_add_r;
  logic [SIDX_W-1:0] src_idx_r;
  logic [DST_W-1:0]  dst_idx_r;

  // output register
  logic              out_valid_r;
  logic [SRC_W-1:0]  out_src_r;
  logic [DST_W-1:0]  out_dst_r;
  logic              out_copy_r;
  logic              out_last_r;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic             empty;
  logic [POS_W-1:0] c_in, r_in;
  logic [DIM_W-1:0] c_inc, r_inc;
  logic [DIM_W-1:0] c13, r13, h_m1_r, w_m1_c;
  logic [DIM_W-1:0] mul_a, mul_b, add_s;
  logic [2*DIM_W-1:0] src_prod_full;
  logic [DIM_W-1:0]   row_abs;
  logic [2*DIM_W-1:0] dst_prod_full;
  logic [SIDX_W+BPP_W-1:0] src_scaled;
  logic [DST_W+BPP_W-1:0]  dst_scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_stride_r <= DIM_W'(1);
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      rect_width_r  <= '0;
      rect_height_r <= '0;
      rotation_r    <= ROT_0;
      bpp_r         <= BPP_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEST_STRIDE: dest_stride_r <= cfg_wdata;
        CFG_ORIGIN_X:    origin_x_r    <= cfg_wdata[POS_W-1:0];
        CFG_ORIGIN_Y:    origin_y_r    <= cfg_wdata[POS_W-1:0];
        CFG_RECT_WIDTH:  rect_width_r  <= cfg_wdata;
        CFG_RECT_HEIGHT: rect_height_r <= cfg_wdata;
        CFG_ROTATION:    rotation_r    <= rot_t'(cfg_wdata[1:0]);
        CFG_BPP:         bpp_r         <= cfg_wdata[BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // saturate the rectangle size
  assign w_eff = (rect_width_r  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rect_width_r;
  assign h_eff = (rect_height_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rect_height_r;
  assign empty = (w_eff == '0) || (h_eff == '0);

  assign c_in = restart ? '0 : col_r;
  assign r_in = restart ? '0 : row_r;

  // pick the pixel of this request and step the walk
  always_comb begin
    cur_c_nxt = c_in;
    cur_r_nxt = r_in;
    if (({1'b0, c_in} >= w_eff) || ({1'b0, r_in} >= h_eff)) begin
      cur_c_nxt = '0;
      cur_r_nxt = '0;
    end
    last_nxt = ({1'b0, cur_c_nxt} == w_eff - DIM_W'(1)) &&
               ({1'b0, cur_r_nxt} == h_eff - DIM_W'(1));
    c_inc = {1'b0, cur_c_nxt} + DIM_W'(1);
    r_inc = {1'b0, cur_r_nxt} + DIM_W'(1);
    if (empty) begin
      col_nxt = c_in;
      row_nxt = r_in;
    end else if (c_inc == w_eff) begin
      col_nxt = '0;
      row_nxt = (r_inc == h_eff) ? '0 : r_inc[POS_W-1:0];
    end else begin
      col_nxt = c_inc[POS_W-1:0];
      row_nxt = cur_r_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.start) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_c_r <= cur_c_nxt;
      cur_r_r <= cur_r_nxt;
      empty_r <= empty;
      last_r  <= last_nxt;
    end
  end

  // source index operands by rotation
  assign c13    = {1'b0, cur_c_r};
  assign r13    = {1'b0, cur_r_r};
  assign h_m1_r = h_eff - DIM_W'(1) - r13;
  assign w_m1_c = w_eff - DIM_W'(1) - c13;

  always_comb begin
    case (rotation_r)
      ROT_90: begin
        mul_a = c13;
        mul_b = h_eff;
        add_s = h_m1_r;
      end
      ROT_180: begin
        mul_a = h_m1_r;
        mul_b = w_eff;
        add_s = w_m1_c;
      end
      ROT_270: begin
        mul_a = w_m1_c;
        mul_b = h_eff;
        add_s = r13;
      end
      default: begin
        mul_a = r13;
        mul_b = w_eff;
        add_s = c13;
      end
    endcase
  end

  assign src_prod_full = mul_a * mul_b;
  assign row_abs       = {1'b0, origin_y_r} + r13;
  assign dst_prod_full = row_abs * dest_stride_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      src_prod_r <= src_prod_full[SIDX_W-1:0];
      src_add_r  <= add_s;
      dst_prod_r <= {1'b0, dst_prod_full};
      dst_add_r  <= {1'b0, origin_x_r} + c13;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_en) begin
      src_idx_r <= src_prod_r + {{(SIDX_W-DIM_W){1'b0}}, src_add_r};
      dst_idx_r <= dst_prod_r + {{(DST_W-DIM_W){1'b0}}, dst_add_r};
    end
  end

  // byte offsets wrap at the field widths
  assign src_scaled = src_idx_r * bpp_r;
  assign dst_scaled = dst_idx_r * bpp_r;

  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (empty_r) begin
        out_src_r  <= '0;
        out_dst_r  <= '0;
        out_copy_r <= 1'b0;
        out_last_r <= 1'b0;
      end else begin
        out_src_r  <= src_scaled[SRC_W-1:0];
        out_dst_r  <= dst_scaled[DST_W-1:0];
        out_copy_r <= 1'b1;
        out_last_r <= last_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-SRC_W-DST_W){1'b0}}, out_dst_r, out_src_r};
  assign out_tuser  = out_copy_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ----- src/rotated_blit_address_generator.sv -----
// Rotated blit address generator: each request on the input stream yields one
// source/destination byte offset pair for the next pixel of the destination
// rectangle, walked in row-major order and wrapping after the last pixel
// (tlast). A request is accepted in the idle state, which latches the position;
// the result then passes the multiply, add and scale (by bytes per pixel) steps
// into the output register, and no new request is taken before it gets there.
// The next request is taken while a finished result still waits on the output;
// it then holds in the scale step, with the input stalled, until the output
// register drains. Setting restart in a request begins the walk again at the
// first pixel. An empty rectangle returns a result with tuser low and zero offsets.
// Configuration is to be written only while idle, by the user; the block has no check.
`default_nettype none
module rotated_blit_address_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rbag_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [rbag_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rbag_pkg::IN_DW-1:0]    in_tdata,   // [0] restart, rest zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rbag_pkg::OUT_DW-1:0]   out_tdata,  // [25:0] src_byte_offset, [52:26] dst_byte_offset
  output logic                          out_tuser,  // [0] copy_valid
  output logic                          out_tlast
);
  import rbag_pkg::*;

  rbag_cmd_t cmd;
  rbag_sts_t sts;

  rbag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rbag_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .restart    (in_tdata[0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  // a last pixel is always a real copy
  a_last_is_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser)
    else $error("last pixel marked on an empty result");

  // empty rectangle gives zero offsets
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("nonzero offsets on an empty result");

  // a load never overwrites a result that is not being taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_tvalid || out_tready))
    else $error("output register overwritten");

endmodule
`default_nettype wire
